### rtl/cra_pkg.sv
// Package for the command retry and acknowledge engine.
// Holds the queue sizing, request, event and register codes, and the event record.
// No dependencies.
package cra_pkg;

   // Pending command queue sizing
   localparam int QUEUE_DEPTH = 8;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result items one input item can cause
   localparam int MAX_EVENTS  = 3;
   localparam int ECNT_W      = 2;

   // Attempt counter saturation
   localparam logic [3:0] ATTEMPT_MAX = 4'd15;

   // Acknowledge codes
   localparam logic [7:0] CODE_ACCEPTED    = 8'd0;
   localparam logic [7:0] CODE_IN_PROGRESS = 8'd5;

   // Register reset values
   localparam logic [3:0]  MAX_ATTEMPTS_RST  = 4'd3;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_ACK     = 2'd1,
      REQ_TICK    = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      KIND_SEND         = 3'd0,
      KIND_RESULT       = 3'd1,
      KIND_FAIL_RESULT  = 3'd2,
      KIND_FAIL_TIMEOUT = 3'd3,
      KIND_DROPPED      = 3'd4
   } event_kind_type;

   typedef enum logic [3:0] {
      CSR_MAX_ATTEMPTS  = 4'd0,
      CSR_TIMEOUT_TICKS = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] cmd;
      logic [7:0]  tag;
      logic [3:0]  attempt;
      logic [7:0]  code;
      logic        last;
   } event_type;

endpackage

### rtl/command_retry_ack_engine.sv
// The first result item is presented in the cycle after its input is accepted. One
// input item per cycle when it causes at most one result and rsp_ready is high; an
// item causing more waits until the three-entry result buffer, draining one item per
// cycle as taken, is down to its last item. Reset is synchronous, active high: it
// empties the queue and result buffer, stops the timer and loads max_attempts 3,
// timeout_ticks 1000. The queue storage is not cleared and needs no clearing pass.
module command_retry_ack_engine
   import cra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_cmd_id,
   input  logic [7:0]  req_payload_tag,
   input  logic [7:0]  req_ack_code,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [15:0] rsp_event_cmd,
   output logic [7:0]  rsp_event_tag,
   output logic [3:0]  rsp_attempt_no,
   output logic [7:0]  rsp_result_code,
   output logic        rsp_last_event,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Configuration registers
   logic [3:0]  max_attempts_ff;
   logic [15:0] timeout_ticks_ff;

   // Queue of pending commands
   logic [15:0]       fifo_cmd_ff [QUEUE_DEPTH];
   logic [7:0]        fifo_tag_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              fifo_wr;

   // In-flight command
   logic        busy_ff, busy_in;
   logic [15:0] cur_cmd_ff, cur_cmd_in;
   logic [7:0]  cur_tag_ff, cur_tag_in;
   logic [3:0]  cur_att_ff, cur_att_in;
   logic [15:0] wait_ff, wait_in;

   // Result buffer
   event_type         ev_ff [MAX_EVENTS];
   event_type         ev_list [MAX_EVENTS];
   logic [ECNT_W-1:0] ev_cnt_ff;
   logic [ECNT_W-1:0] n_ev;

   // Helpers for the item logic
   logic        accept, pop, cmd_match, queue_full, has_next;
   logic [15:0] wait_dec;
   logic [3:0]  att_inc;
   logic [15:0] next_cmd;
   logic [7:0]  next_tag;

   assign csr_ready = 1'b1;
   assign rsp_valid = (ev_cnt_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (ev_cnt_ff == '0) || ((ev_cnt_ff == ECNT_W'(1)) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_event_kind  = ev_ff[0].kind;
   assign rsp_event_cmd   = ev_ff[0].cmd;
   assign rsp_event_tag   = ev_ff[0].tag;
   assign rsp_attempt_no  = ev_ff[0].attempt;
   assign rsp_result_code = ev_ff[0].code;
   assign rsp_last_event  = ev_ff[0].last;

   assign cmd_match  = (req_cmd_id == cur_cmd_ff);
   assign queue_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign has_next   = (count_ff != '0);
   assign wait_dec   = (wait_ff != '0) ? wait_ff - 16'd1 : 16'd0;
   assign att_inc    = (cur_att_ff == ATTEMPT_MAX) ? ATTEMPT_MAX : cur_att_ff + 4'd1;
   assign next_cmd   = fifo_cmd_ff[head_ff];
   assign next_tag   = fifo_tag_ff[head_ff];

   // Work out the new state and the result items of one input item
   always_comb begin
      busy_in    = busy_ff;
      cur_cmd_in = cur_cmd_ff;
      cur_tag_in = cur_tag_ff;
      cur_att_in = cur_att_ff;
      wait_in    = wait_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      fifo_wr    = 1'b0;
      n_ev       = '0;
      for (int i = 0; i < MAX_EVENTS; i++) begin
         ev_list[i] = '0;
      end

      unique case (req_kind_type'(req_type))
         REQ_ENQUEUE: begin
            if (!busy_ff) begin
               busy_in    = 1'b1;
               cur_cmd_in = req_cmd_id;
               cur_tag_in = req_payload_tag;
               cur_att_in = 4'd1;
               wait_in    = timeout_ticks_ff;
               ev_list[0] = '{KIND_SEND, req_cmd_id, req_payload_tag, 4'd1, 8'd0, 1'b0};
               n_ev       = ECNT_W'(1);
            end else if (queue_full) begin
               ev_list[0] = '{KIND_DROPPED, req_cmd_id, 8'd0, 4'd0, 8'd0, 1'b0};
               n_ev       = ECNT_W'(1);
            end else begin
               fifo_wr  = 1'b1;
               tail_in  = (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QIDX_W'(1);
               count_in = count_ff + QCNT_W'(1);
            end
         end
         REQ_ACK, REQ_TICK: begin
            // decide whether the in-flight command resends or finishes
            logic finish;
            finish = 1'b0;
            if (busy_ff && req_type == REQ_ACK && cmd_match) begin
               if (req_ack_code == CODE_IN_PROGRESS) begin
                  wait_in = timeout_ticks_ff;
               end else begin
                  finish = 1'b1;
               end
            end else if (busy_ff && req_type == REQ_TICK) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  if (cur_att_ff < max_attempts_ff) begin
                     cur_att_in = att_inc;
                     wait_in    = timeout_ticks_ff;
                     ev_list[0] = '{KIND_SEND, cur_cmd_ff, cur_tag_ff, att_inc, 8'd0, 1'b0};
                     n_ev       = ECNT_W'(1);
                  end else begin
                     finish = 1'b1;
                  end
               end
            end

            // finish: start the next queued command or go idle, then report
            if (finish) begin
               if (has_next) begin
                  cur_cmd_in = next_cmd;
                  cur_tag_in = next_tag;
                  cur_att_in = 4'd1;
                  wait_in    = timeout_ticks_ff;
                  head_in    = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QIDX_W'(1);
                  count_in   = count_ff - QCNT_W'(1);
                  ev_list[0] = '{KIND_SEND, next_cmd, next_tag, 4'd1, 8'd0, 1'b0};
                  n_ev       = ECNT_W'(1);
               end else begin
                  busy_in    = 1'b0;
                  cur_cmd_in = '0;
                  cur_tag_in = '0;
                  cur_att_in = '0;
                  wait_in    = '0;
               end
               if (req_type == REQ_ACK) begin
                  ev_list[n_ev] = '{KIND_RESULT, cur_cmd_ff, 8'd0, 4'd0, req_ack_code, 1'b0};
                  n_ev          = n_ev + ECNT_W'(1);
                  if (req_ack_code != CODE_ACCEPTED) begin
                     ev_list[n_ev] = '{KIND_FAIL_RESULT, cur_cmd_ff, 8'd0, 4'd0,
                                       req_ack_code, 1'b0};
                     n_ev          = n_ev + ECNT_W'(1);
                  end
               end else begin
                  ev_list[n_ev] = '{KIND_FAIL_TIMEOUT, cur_cmd_ff, 8'd0, 4'd0, 8'd0, 1'b0};
                  n_ev          = n_ev + ECNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase

      // mark the final result item of this input
      for (int i = 0; i < MAX_EVENTS; i++) begin
         ev_list[i].last = (n_ev != '0) && (ECNT_W'(i) == n_ev - ECNT_W'(1));
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff  <= MAX_ATTEMPTS_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_ATTEMPTS:  max_attempts_ff  <= csr_data[3:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Queue storage: write at tail on enqueue
   always_ff @(posedge clock) begin
      if (accept && fifo_wr) begin
         fifo_cmd_ff[tail_ff] <= req_cmd_id;
         fifo_tag_ff[tail_ff] <= req_payload_tag;
      end
   end

   // Control state: advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cur_cmd_ff <= '0;
         cur_tag_ff <= '0;
         cur_att_ff <= '0;
         wait_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
      end else if (accept) begin
         busy_ff    <= busy_in;
         cur_cmd_ff <= cur_cmd_in;
         cur_tag_ff <= cur_tag_in;
         cur_att_ff <= cur_att_in;
         wait_ff    <= wait_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
      end
   end

   // Result buffer: load on accept, shift down on each taken item
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_cnt_ff <= '0;
      end else if (accept) begin
         ev_cnt_ff <= n_ev;
      end else if (pop) begin
         ev_cnt_ff <= ev_cnt_ff - ECNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_ff[i] <= ev_list[i];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_EVENTS - 1; i++) begin
            ev_ff[i] <= ev_ff[i + 1];
         end
      end
   end

`ifndef SYNTH
   // result buffer never holds more than MAX_EVENTS items, one item's results
   assert property (@(posedge clock) disable iff (reset)
      ev_cnt_ff <= ECNT_W'(MAX_EVENTS))
      else $error("result buffer overfilled");

   // nothing queued and no timer running while idle
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (count_ff == '0) && (wait_ff == '0))
      else $error("idle engine holds queued commands or a running timer");

   // an accepted enqueue leaves results unless it was absorbed into state
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == REQ_ENQUEUE) |=> rsp_valid || busy_ff)
      else $error("enqueue lost");

   // the last buffered item carries the last flag
   assert property (@(posedge clock) disable iff (reset)
      (ev_cnt_ff == ECNT_W'(1)) |-> ev_ff[0].last)
      else $error("final result item not marked last");

   // queue never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
